[sv/status_led_breathing_color_unit_assert.svh]
// Assertion macros for the status LED color unit
`ifndef STATUS_LED_BREATHING_COLOR_UNIT_ASSERT_SVH
`define STATUS_LED_BREATHING_COLOR_UNIT_ASSERT_SVH

// checked on every clock outside reset
`define SLBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock, reset included
`define SLBC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/slbc_pkg.sv]
package slbc_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned PHASE_W   = 8;

  localparam int unsigned PERIOD_MS   = 20;
  localparam int unsigned PHASE_STEPS = 150;
  localparam int unsigned HALF_STEPS  = PHASE_STEPS / 2;
  localparam int unsigned HALF_ROUND  = HALF_STEPS / 2;
  localparam int unsigned LEVEL_MIN   = 1;
  localparam int unsigned LEVEL_MAX   = 45;
  localparam int unsigned Q15_ONE     = 32768;
  localparam int unsigned Q15_HALF    = 16384;
  localparam int unsigned EASE_K      = 98304;
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned RED_MS      = 140;
  localparam int unsigned YEL_MS      = 120;
  localparam int unsigned FLASH_RED   = 48;
  localparam int unsigned FLASH_YEL_G = 32;

  // divider / multiplier sizing
  localparam int unsigned HALF_W  = $clog2(HALF_STEPS + 1);
  localparam int unsigned XDIV_W  = HALF_W + 15;
  localparam int unsigned XDVS_W  = $clog2(HALF_STEPS + 1);
  localparam int unsigned CYC_W   = CFG_W + 1;
  localparam int unsigned MSDVS_W = $clog2(MS_PER_SEC + 1);
  localparam int unsigned Q_W     = 17;
  localparam int unsigned PROD_W  = 2 * Q_W;

  localparam logic [CFG_W-1:0] MAG_BASE_RST  = 16'd1500;
  localparam logic [CFG_W-1:0] MAG_GREEN_RST = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_MAG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_GREEN = 2'd1;

  typedef struct packed {
    logic [NOW_W-1:0] now_time;
    logic             nine_axis;
    logic             cal_failed;
    logic             mag_reject;
    logic             reboot_pending;
    logic             log_error;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } out_t;

endpackage

[sv/slbc_div.sv]
`include "status_led_breathing_color_unit_assert.svh"

module slbc_div import slbc_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] divisor_q, divisor_d;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = CW'(DW);
      quo_d     = dividend_i;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  `SLBC_ASSERT(a_busy_cnt, busy_q |-> cnt_q != '0, "divider busy with zero count")
  `SLBC_ASSERT(a_rem_range, $fell(busy_q) && divisor_q != '0 |-> rem_q < divisor_q,
               "remainder not below divisor")
  `SLBC_ASSERT(a_hold, !busy_q && !start_i |=> $stable(rem_q) && $stable(quo_q),
               "idle divider result changed")

endmodule

[sv/slbc_mul.sv]
module slbc_mul import slbc_pkg::*; #(
  parameter int unsigned AW = 17,
  parameter int unsigned BW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [BW-1:0] lo_q, lo_d;
  logic [AW:0]   sum;

  // shift-add, one multiplier bit per cycle
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(BW);
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = sum[AW:1];
      lo_d  = {sum[0], lo_q[BW-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

endmodule

[sv/status_led_breathing_color_unit.sv]
// Status LED color unit. Takes one status request at a time; a request that
// arrives less than PERIOD_MS ms after the current slot is absorbed with no
// output. Otherwise it yields one RGB color: three bit-serial dividers run
// side by side (time mod 1000, time mod reject cycle, smoothstep abscissa),
// then two passes go through one shared bit-serial multiplier. The color sits
// in an output register, so the result may wait for the consumer while the
// next request is already being accepted. mag_base_time / mag_green_time are
// to be written through the cfg port only while the unit is idle; the unit
// itself does not enforce this. No reset sweep is needed.
`include "status_led_breathing_color_unit_assert.svh"

module status_led_breathing_color_unit import slbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [NOW_W-1:0]   slot_q;
  logic [PHASE_W-1:0] phase_q;
  logic [CFG_W-1:0]   base_q, green_q;
  in_t                req_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               accept;
  logic               emit;
  logic [NOW_W-1:0]   gap;
  logic               gap_ok, resync;
  logic [PHASE_W-1:0] ph_clamp, half, phase_nxt;
  logic [XDIV_W-1:0]  x_dividend;
  logic [CYC_W-1:0]   cycle_w;

  logic               dc_busy, dm_busy, dx_busy;
  logic [NOW_W-1:0]   dc_quot, dm_quot;
  logic [CYC_W-1:0]   dc_rem;
  logic [MSDVS_W-1:0] dm_rem;
  logic [XDIV_W-1:0]  dx_quot;
  logic [XDVS_W-1:0]  dx_rem;
  logic               div_start;

  logic               mul_start, mul_busy;
  logic [Q_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     x_val, x2, eased;

  logic [23:0]        lvl_sum;
  logic [COLOR_W-1:0] level;
  logic [CYC_W-1:0]   pos;
  logic               alt;
  out_t               color;

  assign accept    = in_valid_i && in_ready_o;
  assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign gap       = in_i.now_time - slot_q;
  assign gap_ok    = gap >= NOW_W'(PERIOD_MS);
  assign resync    = gap >= NOW_W'(3 * PERIOD_MS);
  assign div_start = accept && gap_ok;

  assign ph_clamp   = (phase_q >= PHASE_W'(PHASE_STEPS)) ? PHASE_W'(PHASE_STEPS - 1) : phase_q;
  assign half       = (ph_clamp <= PHASE_W'(HALF_STEPS)) ? ph_clamp
                                                         : PHASE_W'(PHASE_STEPS) - ph_clamp;
  assign x_dividend = {half[HALF_W-1:0], 15'd0} + XDIV_W'(HALF_ROUND);
  assign phase_nxt  = (ph_clamp == PHASE_W'(PHASE_STEPS - 1)) ? '0 : ph_clamp + PHASE_W'(1);
  assign cycle_w    = {1'b0, base_q} + {1'b0, green_q};

  slbc_div #(.DW(NOW_W), .VW(CYC_W)) u_div_cyc (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(in_i.now_time),
    .divisor_i (cycle_w),
    .busy_o    (dc_busy),
    .quot_o    (dc_quot),
    .rem_o     (dc_rem)
  );

  slbc_div #(.DW(NOW_W), .VW(MSDVS_W)) u_div_ms (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(in_i.now_time),
    .divisor_i (MSDVS_W'(MS_PER_SEC)),
    .busy_o    (dm_busy),
    .quot_o    (dm_quot),
    .rem_o     (dm_rem)
  );

  slbc_div #(.DW(XDIV_W), .VW(XDVS_W)) u_div_x (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(x_dividend),
    .divisor_i (XDVS_W'(HALF_STEPS)),
    .busy_o    (dx_busy),
    .quot_o    (dx_quot),
    .rem_o     (dx_rem)
  );

  assign x_val = dx_quot[Q_W-1:0];
  assign x2    = prod[Q_W+14:15];
  assign eased = prod[Q_W+14:15];

  assign mul_start = ((state_q == S_DIV) && !dc_busy && !dm_busy && !dx_busy) ||
                     ((state_q == S_MUL1) && !mul_busy);
  assign mul_a     = (state_q == S_DIV) ? x_val : x2;
  assign mul_b     = (state_q == S_DIV) ? x_val : Q_W'(EASE_K) - {x_val[Q_W-2:0], 1'b0};

  slbc_mul #(.AW(Q_W), .BW(Q_W)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .prod_o (prod)
  );

  always_comb begin
    lvl_sum = {7'd0, eased} * 24'(LEVEL_MAX - LEVEL_MIN) + 24'(Q15_HALF);
    level   = COLOR_W'(LEVEL_MIN) + lvl_sum[22:15];
    pos     = (cycle_w != '0) ? dc_rem : '0;
    alt     = req_q.mag_reject && req_q.nine_axis && (pos >= {1'b0, base_q});
    color.red   = '0;
    color.green = level;
    color.blue  = (req_q.nine_axis && !alt) ? level : '0;
    if (req_q.cal_failed && dm_rem < MSDVS_W'(RED_MS)) begin
      color.red   = COLOR_W'(FLASH_RED);
      color.green = '0;
      color.blue  = '0;
    end else if ((req_q.reboot_pending || req_q.log_error) && dm_rem < MSDVS_W'(YEL_MS)) begin
      color.red   = COLOR_W'(FLASH_RED);
      color.green = COLOR_W'(FLASH_YEL_G);
      color.blue  = '0;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      phase_q     <= '0;
      base_q      <= MAG_BASE_RST;
      green_q     <= MAG_GREEN_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAG_BASE:  base_q  <= cfg_data_i;
          CFG_MAG_GREEN: green_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (div_start) begin
            slot_q  <= resync ? in_i.now_time : slot_q + NOW_W'(PERIOD_MS);
            phase_q <= phase_nxt;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (mul_start) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_start) begin
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (!mul_busy) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_i;
    end
    if (emit) begin
      out_q <= color;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SLBC_ASSERT(a_phase_range, phase_q < PHASE_W'(PHASE_STEPS), "breath phase out of range")
  `SLBC_ASSERT(a_idle_units, state_q == S_IDLE |-> !dc_busy && !dm_busy && !dx_busy && !mul_busy,
               "arithmetic unit busy while idle")
  `SLBC_ASSERT(a_slot_move, div_start |=> slot_q != $past(slot_q), "slot time did not advance")
  `SLBC_ASSERT(a_x_range, state_q == S_MUL1 |-> x_val <= Q_W'(Q15_ONE), "smoothstep input above one")

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slbc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RST_CYCLES   = 6;
  localparam int unsigned SETTLE       = 100;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PER_PHASE    = 215;
  localparam int unsigned N_PHASES     = 6;

  localparam int unsigned SLOT_MS   = 20;
  localparam int unsigned RESYNC_MS = 60;
  localparam int unsigned N_STEPS   = 150;
  localparam int unsigned N_HALF    = 75;
  localparam int unsigned LVL_LO    = 1;
  localparam int unsigned LVL_HI    = 45;
  localparam int unsigned RED_WIN   = 140;
  localparam int unsigned YEL_WIN   = 120;
  localparam int unsigned FLASH_R   = 48;
  localparam int unsigned FLASH_G   = 32;

  typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_RGB} chk_e;

  // flg = {nine_axis, cal_failed, mag_reject, reboot_pending, log_error}
  typedef struct packed {
    logic [NOW_W-1:0] now;
    logic [4:0]       flg;
    chk_e             kind;
    out_t             rgb;
  } dir_row_t;

  localparam int unsigned N_DIR = 22;

  dir_row_t dir_tbl [N_DIR] = '{
    '{32'd0,          5'b00000, EXP_NONE, 24'h000000},
    '{32'd19,         5'b00000, EXP_NONE, 24'h000000},
    '{32'd20,         5'b00000, EXP_RGB,  24'h000100},
    '{32'd39,         5'b00000, EXP_NONE, 24'h000000},
    '{32'd40,         5'b10000, EXP_PRED, 24'h000000},
    '{32'd1000,       5'b01000, EXP_RGB,  24'h300000},
    '{32'd1139,       5'b01000, EXP_RGB,  24'h300000},
    '{32'd2140,       5'b01000, EXP_PRED, 24'h000000},
    '{32'd3119,       5'b00010, EXP_RGB,  24'h302000},
    '{32'd4000,       5'b00001, EXP_RGB,  24'h302000},
    '{32'd5100,       5'b01010, EXP_RGB,  24'h300000},
    '{32'd6120,       5'b00010, EXP_PRED, 24'h000000},
    '{32'd7300,       5'b00100, EXP_PRED, 24'h000000},
    '{32'd9700,       5'b10100, EXP_PRED, 24'h000000},
    '{32'd10300,      5'b10100, EXP_PRED, 24'h000000},
    '{32'd500,        5'b10000, EXP_PRED, 24'h000000},
    '{32'hFFFF_FFFF,  5'b10011, EXP_PRED, 24'h000000},
    '{32'd19,         5'b00000, EXP_PRED, 24'h000000},
    '{32'd78,         5'b10000, EXP_PRED, 24'h000000},
    '{32'd99,         5'b00000, EXP_PRED, 24'h000000},
    '{32'd118,        5'b00000, EXP_NONE, 24'h000000},
    '{32'd12345,      5'b11111, EXP_PRED, 24'h000000}
  };

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_color;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_MAG_BASE;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic [NOW_W-1:0]   slot_ms   = '0;
  logic [PHASE_W-1:0] breath    = '0;
  logic [CFG_W-1:0]   base_ms   = MAG_BASE_RST;
  logic [CFG_W-1:0]   grn_ms    = MAG_GREEN_RST;
  logic [NOW_W-1:0]   t_now     = '0;

  out_t        color_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned snd_idle     = 12;
  int unsigned rcv_idle     = 56;

  status_led_breathing_color_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_color),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [COLOR_W-1:0] breath_level(input logic [PHASE_W-1:0] step);
    longint unsigned s, half, x, x2, eased;
    s = step;
    if (s >= N_STEPS) s = N_STEPS - 1;
    half  = (s <= N_HALF) ? s : N_STEPS - s;
    x     = (half * 32768 + N_HALF / 2) / N_HALF;
    x2    = (x * x) >> 15;
    eased = (x2 * (98304 - 2 * x)) >> 15;
    return COLOR_W'(LVL_LO + (((LVL_HI - LVL_LO) * eased + 16384) >> 15));
  endfunction

  // advances slot time and breathing step; returns 1 when a color is due
  function automatic bit next_color(input in_t r, output out_t c);
    logic [NOW_W-1:0]   gap, cyc, pos, ms;
    logic [COLOR_W-1:0] lvl;
    c   = '0;
    gap = r.now_time - slot_ms;
    if (gap < SLOT_MS) return 1'b0;
    if (gap >= RESYNC_MS) slot_ms = r.now_time;
    else slot_ms = slot_ms + SLOT_MS;
    lvl = breath_level(breath);
    c = '{red: '0, green: lvl, blue: r.nine_axis ? lvl : '0};
    if (r.mag_reject && r.nine_axis) begin
      cyc = NOW_W'(base_ms) + NOW_W'(grn_ms);
      pos = (cyc != 0) ? r.now_time % cyc : '0;
      if (pos >= base_ms) c = '{red: '0, green: lvl, blue: '0};
    end
    ms = r.now_time % 32'd1000;
    if (r.cal_failed && ms < RED_WIN) begin
      c = '{red: COLOR_W'(FLASH_R), green: '0, blue: '0};
    end else if ((r.reboot_pending || r.log_error) && ms < YEL_WIN) begin
      c = '{red: COLOR_W'(FLASH_R), green: COLOR_W'(FLASH_G), blue: '0};
    end
    breath = breath + 1'b1;
    if (breath >= N_STEPS) breath = '0;
    return 1'b1;
  endfunction

  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) t_now = t_now + $urandom_range(15, 25);
    else if (pick < 85) t_now = t_now + $urandom_range(0, 19);
    else if (pick < 93) t_now = t_now + $urandom_range(40, 2500);
    else if (pick < 97) t_now = $urandom();
    else t_now = 32'hFFFF_FFFF - $urandom_range(0, 60);
    r.now_time       = t_now;
    r.nine_axis      = 1'($urandom_range(1));
    r.cal_failed     = ($urandom_range(99) < 15);
    r.mag_reject     = ($urandom_range(99) < 40);
    r.reboot_pending = ($urandom_range(99) < 15);
    r.log_error      = ($urandom_range(99) < 15);
    return r;
  endfunction

  // called and returns on a falling edge; valid stays up until the next call
  task automatic push_request(input in_t req, input chk_e kind, input out_t typed,
                              output bit made);
    out_t col;
    bit   due;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (!in_ready);
    due = next_color(req, col);
    if (kind == EXP_RGB) begin
      due = 1'b1;
      col = typed;
    end else if (kind == EXP_NONE) begin
      due = 1'b0;
    end
    if (due) color_q.push_back(col);
    made = due;
    @(negedge clk_i);
  endtask

  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_reject_cycle(input logic [CFG_W-1:0] base,
                                      input logic [CFG_W-1:0] green);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAG_BASE;
    cfg_data <= base;
    @(negedge clk_i);
    cfg_idx  <= CFG_MAG_GREEN;
    cfg_data <= green;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    base_ms  = base;
    grn_ms   = green;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    out_t exp_c;
    if (rst_ni && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        $error("unexpected color %h", out_color);
        mismatch_cnt++;
      end else begin
        exp_c = color_q.pop_front();
        if (out_color.red !== exp_c.red) begin
          $error("red: expected %0d, got %0d", exp_c.red, out_color.red);
          mismatch_cnt++;
        end
        if (out_color.green !== exp_c.green) begin
          $error("green: expected %0d, got %0d", exp_c.green, out_color.green);
          mismatch_cnt++;
        end
        if (out_color.blue !== exp_c.blue) begin
          $error("blue: expected %0d, got %0d", exp_c.blue, out_color.blue);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_t         req;
    bit          made;
    int unsigned n;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      req = {dir_tbl[i].now, dir_tbl[i].flg};
      push_request(req, dir_tbl[i].kind, dir_tbl[i].rgb, made);
    end
    drain(SETTLE);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: program_reject_cycle(16'd0, 16'd0);
        1: program_reject_cycle(16'hFFFF, 16'hFFFF);
        2: program_reject_cycle(16'd0, 16'hFFFF);
        3: program_reject_cycle(16'hFFFF, 16'd0);
        4: program_reject_cycle(CFG_W'($urandom_range(0, 300)),
                                CFG_W'($urandom_range(0, 300)));
        default: program_reject_cycle(MAG_BASE_RST, MAG_GREEN_RST);
      endcase
      snd_idle = (ph < 2) ? 12 : (ph < 4) ? 56 : 0;
      rcv_idle = (ph < 2) ? 56 : (ph < 4) ? 12 : 0;
      n = 0;
      while (n < PER_PHASE) begin
        if (ph == 1 && n == 100) drain(0);
        req = random_request();
        push_request(req, EXP_PRED, '0, made);
        n++;
      end
      drain(SETTLE);
    end

    if (mismatch_cnt == 0 && color_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
